// ===== hw/rtl/u8chk_pkg.sv =====
// Shared types, status codes and character constants for the UTF-8 source text checker.
// Depends on nothing; used by u8chk_core and utf8_source_text_checker_top.
package u8chk_pkg;

    // Width of every result field and of the size limit register
    localparam int FIELD_BITS = 25;
    localparam int CP_BITS    = 21;

    // Reset value of the size limit: 16 MiB
    localparam logic [FIELD_BITS-1:0] MAX_BYTES_RESET = FIELD_BITS'(16 * 1024 * 1024);

    // Characters the checker looks at
    localparam logic [7:0]         CHAR_TAB    = 8'h09;
    localparam logic [7:0]         CHAR_SPACE  = 8'h20;
    localparam logic [CP_BITS-1:0] CP_LF       = 21'h0000A;
    localparam logic [CP_BITS-1:0] CP_CR       = 21'h0000D;
    localparam logic [CP_BITS-1:0] CP_TAB      = 21'h00009;
    localparam logic [CP_BITS-1:0] CP_SPACE    = 21'h00020;
    localparam logic [CP_BITS-1:0] CP_SMALL_O  = 21'h0006F;
    localparam logic [CP_BITS-1:0] CP_DIAERESIS = 21'h00308;
    localparam logic [CP_BITS-1:0] CP_ESC      = 21'h0001B;
    localparam logic [CP_BITS-1:0] CP_DEL      = 21'h0007F;
    localparam logic [CP_BITS-1:0] CP_ZWSP     = 21'h0200B;
    localparam logic [CP_BITS-1:0] CP_ZWJ      = 21'h0200D;
    localparam logic [CP_BITS-1:0] CP_WJ       = 21'h02060;
    localparam logic [CP_BITS-1:0] CP_BOM      = 21'h0FEFF;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_BOM       = 3'd2,
        ST_INVALID   = 3'd3,
        ST_CR        = 3'd4,
        ST_TRAILING  = 3'd5,
        ST_CONTROL   = 3'd6
    } status_t;

    // Input request: one source byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    // Result request: one verdict
    typedef struct packed {
        status_t                status;
        logic [FIELD_BITS-1:0]  error_offset;
        logic [FIELD_BITS-1:0]  error_line;
        logic [FIELD_BITS-1:0]  error_column;
    } out_t;

    // Code points that may not appear in source text
    function automatic logic is_control(input logic [CP_BITS-1:0] cp);
        logic hit;
        hit = (cp == 21'h00000) || (cp == 21'h00007) || (cp == 21'h00008)
            || (cp == 21'h0000B) || (cp == 21'h0000C)
            || (cp == CP_ESC) || (cp == CP_DEL)
            || (cp >= 21'h00080 && cp <= 21'h0009F)
            || (cp >= CP_ZWSP && cp <= CP_ZWJ)
            || (cp == CP_WJ) || (cp == CP_BOM);
        return hit;
    endfunction

endpackage

// ===== hw/rtl/u8chk_core.sv =====
// Stream state of the checker: UTF-8 decode, line/column tracking, first-fault capture.
// Depends on u8chk_pkg. Updates once per processed byte and forms the verdict on the last byte.
module u8chk_core #(
    parameter int COUNTER_BITS = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  u8chk_pkg::in_t                    item,
    input  logic [u8chk_pkg::FIELD_BITS-1:0]  max_bytes,
    output u8chk_pkg::out_t                   verdict
);
    import u8chk_pkg::*;

    localparam int CB       = COUNTER_BITS;
    localparam int CMP_BITS = (CB > FIELD_BITS) ? CB : FIELD_BITS;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam logic [CB-1:0] CNT_ONE = CB'(1);

    logic [CB-1:0]      byte_count_reg, byte_count_next;
    logic [CB-1:0]      line_reg, line_next;
    logic [CB-1:0]      col_reg, col_next;
    logic [CP_BITS-1:0] acc_reg, acc_next;
    logic [1:0]         rem_reg, rem_next;
    logic [1:0]         seq_len_reg, seq_len_next;
    logic [CB-1:0]      seq_start_reg, seq_start_next;
    logic [CP_BITS-1:0] prev_cp_reg, prev_cp_next;
    logic [7:0]         prev_byte_reg, prev_byte_next;
    logic               has_text_reg, has_text_next;
    status_t            fault_code_reg, fault_code_next;
    logic [CB-1:0]      fault_off_reg, fault_off_next;
    logic [CB-1:0]      fault_line_reg, fault_line_next;
    logic [CB-1:0]      fault_col_reg, fault_col_next;

    logic [7:0]         b;
    logic               cp_fire;
    logic [CP_BITS-1:0] cp_val;
    logic [CB-1:0]      cp_at;
    logic               first_bad;

    assign b = item.data_byte;

    // Second byte range rules for E0, ED, F0 and F4 leads
    always_comb
    begin
        first_bad = 1'b0;
        if (rem_reg == seq_len_reg) begin
            if (seq_len_reg == 2'd2 && acc_reg == 21'h0 && b < 8'hA0) first_bad = 1'b1;
            if (seq_len_reg == 2'd2 && acc_reg == 21'hD && b > 8'h9F) first_bad = 1'b1;
            if (seq_len_reg == 2'd3 && acc_reg == 21'h0 && b < 8'h90) first_bad = 1'b1;
            if (seq_len_reg == 2'd3 && acc_reg == 21'h4 && b > 8'h8F) first_bad = 1'b1;
        end
    end

    // Next state for one byte
    always_comb
    begin
        byte_count_next = byte_count_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        seq_len_next    = seq_len_reg;
        seq_start_next  = seq_start_reg;
        prev_cp_next    = prev_cp_reg;
        has_text_next   = has_text_reg;
        fault_code_next = fault_code_reg;
        fault_off_next  = fault_off_reg;
        fault_line_next = fault_line_reg;
        fault_col_next  = fault_col_reg;
        cp_fire         = 1'b0;
        cp_val          = '0;
        cp_at           = seq_start_reg;

        if (fault_code_reg == ST_OK) begin
            // decode
            if (rem_reg == 2'd0) begin
                seq_start_next = byte_count_reg;
                cp_at          = byte_count_reg;
                if (!b[7]) begin
                    seq_len_next = 2'd0;
                    cp_fire      = 1'b1;
                    cp_val       = CP_BITS'(b);
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_len_next = 2'd1;
                    rem_next     = 2'd1;
                    acc_next     = CP_BITS'(b[4:0]);
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    seq_len_next = 2'd2;
                    rem_next     = 2'd2;
                    acc_next     = CP_BITS'(b[3:0]);
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    seq_len_next = 2'd3;
                    rem_next     = 2'd3;
                    acc_next     = CP_BITS'(b[2:0]);
                end else begin
                    fault_code_next = ST_INVALID;
                    fault_off_next  = byte_count_reg;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end
            end else if (b[7:6] != 2'b10 || first_bad) begin
                fault_code_next = ST_INVALID;
                fault_off_next  = seq_start_reg;
                fault_line_next = line_reg;
                fault_col_next  = col_reg;
            end else begin
                acc_next = {acc_reg[CP_BITS-7:0], b[5:0]};
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1) begin
                    cp_fire = 1'b1;
                    cp_val  = {acc_reg[CP_BITS-7:0], b[5:0]};
                end
            end

            // finished code point
            if (cp_fire) begin
                if (cp_at == '0 && cp_val == CP_BOM) begin
                    fault_code_next = ST_BOM;
                    fault_off_next  = '0;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end else if (cp_val == CP_CR) begin
                    fault_code_next = ST_CR;
                    fault_off_next  = cp_at;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end else if (cp_val == CP_LF) begin
                    if (has_text_reg && cp_at != '0
                        && (prev_byte_reg == CHAR_SPACE || prev_byte_reg == CHAR_TAB)) begin
                        fault_code_next = ST_TRAILING;
                        fault_off_next  = cp_at - CNT_ONE;
                        fault_line_next = line_reg;
                        fault_col_next  = col_reg;
                    end else begin
                        line_next     = (line_reg == CNT_MAX) ? line_reg : line_reg + CNT_ONE;
                        col_next      = CNT_ONE;
                        has_text_next = 1'b0;
                        prev_cp_next  = cp_val;
                    end
                end else if (is_control(cp_val)) begin
                    fault_code_next = ST_CONTROL;
                    fault_off_next  = cp_at;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end else if (cp_val == CP_DIAERESIS && prev_cp_reg == CP_SMALL_O) begin
                    // decomposed o is rejected as invalid text
                    fault_code_next = ST_INVALID;
                    fault_off_next  = cp_at;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end else begin
                    if (cp_val != CP_SPACE && cp_val != CP_TAB) has_text_next = 1'b1;
                    col_next     = (col_reg == CNT_MAX) ? col_reg : col_reg + CNT_ONE;
                    prev_cp_next = cp_val;
                end
            end

            // end of source: cut sequence or trailing blank
            if (fault_code_next == ST_OK && item.last) begin
                if (rem_next != 2'd0) begin
                    fault_code_next = ST_INVALID;
                    fault_off_next  = seq_start_next;
                    fault_line_next = line_next;
                    fault_col_next  = col_next;
                end else if (has_text_next && (b == CHAR_SPACE || b == CHAR_TAB)) begin
                    fault_code_next = ST_TRAILING;
                    fault_off_next  = byte_count_reg;
                    fault_line_next = line_next;
                    fault_col_next  = col_next;
                end
            end
        end

        prev_byte_next  = b;
        byte_count_next = (byte_count_reg == CNT_MAX) ? byte_count_reg
                                                      : byte_count_reg + CNT_ONE;
    end

    // Verdict for the last byte; size limit wins over everything
    always_comb
    begin
        if (CMP_BITS'(byte_count_next) > CMP_BITS'(max_bytes)) begin
            verdict.status       = ST_TOO_LARGE;
            verdict.error_offset = max_bytes;
            verdict.error_line   = '0;
            verdict.error_column = '0;
        end else begin
            verdict.status       = fault_code_next;
            verdict.error_offset = FIELD_BITS'(fault_off_next);
            verdict.error_line   = FIELD_BITS'(fault_line_next);
            verdict.error_column = FIELD_BITS'(fault_col_next);
        end
    end

    // State registers; the stream state restarts after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg <= '0;
            line_reg       <= CNT_ONE;
            col_reg        <= CNT_ONE;
            acc_reg        <= '0;
            rem_reg        <= '0;
            seq_len_reg    <= '0;
            seq_start_reg  <= '0;
            prev_cp_reg    <= '0;
            prev_byte_reg  <= '0;
            has_text_reg   <= 1'b0;
            fault_code_reg <= ST_OK;
            fault_off_reg  <= '0;
            fault_line_reg <= '0;
            fault_col_reg  <= '0;
        end else if (fire) begin
            if (item.last) begin
                byte_count_reg <= '0;
                line_reg       <= CNT_ONE;
                col_reg        <= CNT_ONE;
                acc_reg        <= '0;
                rem_reg        <= '0;
                seq_len_reg    <= '0;
                seq_start_reg  <= '0;
                prev_cp_reg    <= '0;
                prev_byte_reg  <= '0;
                has_text_reg   <= 1'b0;
                fault_code_reg <= ST_OK;
                fault_off_reg  <= '0;
                fault_line_reg <= '0;
                fault_col_reg  <= '0;
            end else begin
                byte_count_reg <= byte_count_next;
                line_reg       <= line_next;
                col_reg        <= col_next;
                acc_reg        <= acc_next;
                rem_reg        <= rem_next;
                seq_len_reg    <= seq_len_next;
                seq_start_reg  <= seq_start_next;
                prev_cp_reg    <= prev_cp_next;
                prev_byte_reg  <= prev_byte_next;
                has_text_reg   <= has_text_next;
                fault_code_reg <= fault_code_next;
                fault_off_reg  <= fault_off_next;
                fault_line_reg <= fault_line_next;
                fault_col_reg  <= fault_col_next;
            end
        end
    end

endmodule

// ===== hw/rtl/utf8_source_text_checker_top.sv =====
// Top level of the UTF-8 source text checker: input register, size limit register,
// result register. Depends on u8chk_pkg and u8chk_core.

// Checks a source text streamed one byte per request and returns one verdict request
// for each byte flagged last: the first fault with its byte offset, line and column,
// or "too large" when the source exceeds the size limit register. The block takes
// one byte every cycle unless the input stalls; throughput is set by the state
// update in u8chk_core. A verdict is formed while its last byte sits in the input
// register, and it loads the result register when that byte is processed. The
// input stalls only while a last byte waits in the input register and the result
// register still holds an unaccepted verdict; then no byte moves until that
// verdict is taken. The limit register is written through cfg_valid/cfg_data,
// which is always ready; write it only while idle.
module utf8_source_text_checker_top #(
    parameter int COUNTER_BITS = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [u8chk_pkg::FIELD_BITS-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  u8chk_pkg::in_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output u8chk_pkg::out_t                   out_data
);
    import u8chk_pkg::*;

    logic [FIELD_BITS-1:0] max_bytes_reg;
    logic                  in_valid_reg;
    in_t                   in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_data_reg;
    out_t                  verdict;
    logic                  out_free;
    logic                  proc_fire;

    assign cfg_ready = 1'b1;

    // A byte moves on unless it is last and the result register is still full
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && (!in_data_reg.last || out_free);
    assign in_ready  = !in_valid_reg || proc_fire;

    // Size limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_bytes_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    u8chk_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .item      (in_data_reg),
        .max_bytes (max_bytes_reg),
        .verdict   (verdict)
    );

    // Result register
    always_comb
    begin
        if (proc_fire && in_data_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_data_reg.last)
        begin
            out_data_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
